@@ src/svf_pkg.sv @@
// ----------------------------------------------------------------------------
// svf_pkg: shared types, constants and helpers of the state variable filter
// Fixed-point formats, coefficient scales, register indexes, sequencer
// states and the saturation, rounding and alignment functions.
// ----------------------------------------------------------------------------
package svf_pkg;

   // sample and integrator formats
   localparam int SAMPLE_WIDTH = 16;              // Q1.15
   localparam int STATE_WIDTH  = 24;              // Q4.20
   localparam int ALIGN_SHIFT  = STATE_WIDTH - SAMPLE_WIDTH - 3;

   // coefficient formats
   localparam int REG_WIDTH   = 16;               // Q0.16 config registers
   localparam int COEF_WIDTH  = 18;               // signed operand, holds 0..65536
   localparam int PROD_WIDTH  = STATE_WIDTH + COEF_WIDTH;
   localparam int FRAC_BITS   = 16;
   localparam int RND_WIDTH   = PROD_WIDTH - FRAC_BITS;
   localparam int EXT_WIDTH   = STATE_WIDTH + 4;  // headroom for sums before clamping

   localparam logic signed [COEF_WIDTH-1:0] FREQ_SCALE = COEF_WIDTH'(61766); // 2*pi*0.15
   localparam logic signed [COEF_WIDTH-1:0] DAMP_SCALE = COEF_WIDTH'(65208); // 0.995
   localparam logic signed [COEF_WIDTH-1:0] COEF_ONE   = COEF_WIDTH'(65536);

   localparam logic [REG_WIDTH-1:0] CUTOFF_RESET    = REG_WIDTH'(16384);
   localparam logic [REG_WIDTH-1:0] RESONANCE_RESET = '0;

   // register indexes
   localparam int CSR_INDEX_WIDTH = 1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CUTOFF    = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RESONANCE = 1'd1;

   localparam int RSP_WIDTH = 4 * SAMPLE_WIDTH;

   // sequencer states, one-hot
   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_COEF_F = 9'b000000010,
      ST_COEF_D = 9'b000000100,
      ST_MUL_FB = 9'b000001000,
      ST_MUL_DB = 9'b000010000,
      ST_HIGH   = 9'b000100000,
      ST_MUL_FH = 9'b001000000,
      ST_BAND   = 9'b010000000,
      ST_DONE   = 9'b100000000
   } seq_state_type;

   typedef logic signed [STATE_WIDTH-1:0]  state_word_type;
   typedef logic signed [SAMPLE_WIDTH-1:0] sample_word_type;

   // clamp a widened sum to the integrator range
   function automatic state_word_type sat_state(input logic signed [EXT_WIDTH-1:0] v);
      logic signed [EXT_WIDTH-1:0] hi;
      logic signed [EXT_WIDTH-1:0] lo;
      hi = EXT_WIDTH'({1'b0, {(STATE_WIDTH-1){1'b1}}});
      lo = -hi - EXT_WIDTH'(1);
      if (v > hi) begin
         return hi[STATE_WIDTH-1:0];
      end else if (v < lo) begin
         return lo[STATE_WIDTH-1:0];
      end
      return v[STATE_WIDTH-1:0];
   endfunction

   // round half up and drop the fraction of a coefficient product
   function automatic logic signed [RND_WIDTH-1:0] round_prod(
      input logic signed [PROD_WIDTH-1:0] p);
      logic signed [PROD_WIDTH-1:0] t;
      t = p + PROD_WIDTH'(1 << (FRAC_BITS - 1));
      return t[PROD_WIDTH-1:FRAC_BITS];
   endfunction

   // bring an integrator-format value back to a saturated sample
   function automatic sample_word_type to_sample(input state_word_type v);
      logic signed [STATE_WIDTH:0]             t;
      logic signed [STATE_WIDTH-ALIGN_SHIFT:0] s;
      logic signed [STATE_WIDTH-ALIGN_SHIFT:0] hi;
      logic signed [STATE_WIDTH-ALIGN_SHIFT:0] lo;
      t  = {v[STATE_WIDTH-1], v} + (STATE_WIDTH+1)'(1 << (ALIGN_SHIFT - 1));
      s  = t[STATE_WIDTH:ALIGN_SHIFT];
      hi = (STATE_WIDTH-ALIGN_SHIFT+1)'({1'b0, {(SAMPLE_WIDTH-1){1'b1}}});
      lo = -hi - (STATE_WIDTH-ALIGN_SHIFT+1)'(1);
      if (s > hi) begin
         return hi[SAMPLE_WIDTH-1:0];
      end else if (s < lo) begin
         return lo[SAMPLE_WIDTH-1:0];
      end
      return s[SAMPLE_WIDTH-1:0];
   endfunction

endpackage

@@ src/state_variable_filter.sv @@
// ----------------------------------------------------------------------------
// state_variable_filter: fixed-point Chamberlin state variable filter
// One sample in, lowpass/highpass/bandpass/notch out, with saturating
// lowpass and bandpass integrators and one shared multiplier.
// ----------------------------------------------------------------------------
//
//   channel  dir  ports                        contents
//   req      in   req_tvalid/tready/tdata      one Q1.15 sample
//   rsp      out  rsp_tvalid/tready/tdata      lowpass, highpass, bandpass, notch
//   csr      in   csr_we/csr_index/csr_wdata   cutoff (0), resonance (1)
//
// A new sample is taken only in the idle state, after the last one is done:
// the single multiplier forms five products in turn (frequency and damping
// coefficients, F*band, D*band, F*high), each registered before use.
// A result waits in the output register while the next sample is computed;
// the sequencer holds in its last step only if that register is still full.
// Reset is synchronous: integrators clear, cutoff goes to 16384, resonance to 0.
// ----------------------------------------------------------------------------
module state_variable_filter (
   input  logic                                  clock,
   input  logic                                  reset,
   // sample input
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [svf_pkg::SAMPLE_WIDTH-1:0]      req_tdata,   // [15:0] sample
   // filter outputs
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [svf_pkg::RSP_WIDTH-1:0]         rsp_tdata,   // [15:0] lowpass,
                                                              // [31:16] highpass,
                                                              // [47:32] bandpass,
                                                              // [63:48] notch
   // configuration writes
   input  logic                                  csr_we,
   input  logic [svf_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [svf_pkg::REG_WIDTH-1:0]         csr_wdata
);
   import svf_pkg::*;

   seq_state_type                 state_ff, state_in;
   logic [REG_WIDTH-1:0]          cutoff_ff, cutoff_in;
   logic [REG_WIDTH-1:0]          resonance_ff, resonance_in;
   state_word_type                low_ff, low_in;
   state_word_type                band_ff, band_in;
   state_word_type                high_ff, high_in;
   state_word_type                notch_ff, notch_in;
   state_word_type                x_ff, x_in;
   logic signed [COEF_WIDTH-1:0]  f_ff, f_in;
   logic signed [COEF_WIDTH-1:0]  d_ff, d_in;
   logic signed [PROD_WIDTH-1:0]  prod_ff, prod_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [RSP_WIDTH-1:0]          rsp_data_ff, rsp_data_in;

   // shared multiplier operands
   state_word_type                mul_a;
   logic signed [COEF_WIDTH-1:0]  mul_b;
   logic signed [RND_WIDTH-1:0]   prod_rnd;
   logic                          req_accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign prod_rnd = round_prod(prod_ff);

   // pick the multiplier operands for the current step
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_COEF_F: begin
            mul_a = STATE_WIDTH'(cutoff_ff);
            mul_b = FREQ_SCALE;
         end
         ST_COEF_D: begin
            mul_a = STATE_WIDTH'(resonance_ff);
            mul_b = DAMP_SCALE;
         end
         ST_MUL_FB: begin
            mul_a = band_ff;
            mul_b = f_ff;
         end
         ST_MUL_DB: begin
            mul_a = band_ff;
            mul_b = d_ff;
         end
         ST_MUL_FH: begin
            mul_a = high_ff;
            mul_b = f_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // sequencer and datapath next values
   always_comb begin
      state_in     = state_ff;
      cutoff_in    = cutoff_ff;
      resonance_in = resonance_ff;
      low_in       = low_ff;
      band_in      = band_ff;
      high_in      = high_ff;
      notch_in     = notch_ff;
      x_in         = x_ff;
      f_in         = f_ff;
      d_in         = d_ff;
      prod_in      = mul_a * mul_b;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      // drop the result once the downstream side takes it
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      // take configuration writes; indexes beyond the list are ignored
      if (csr_we) begin
         if (csr_index == CSR_CUTOFF) begin
            cutoff_in = csr_wdata;
         end
         if (csr_index == CSR_RESONANCE) begin
            resonance_in = csr_wdata;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               x_in = {{(STATE_WIDTH-SAMPLE_WIDTH){req_tdata[SAMPLE_WIDTH-1]}}, req_tdata}
                      <<< ALIGN_SHIFT;
               state_in = ST_COEF_F;
            end
         end
         ST_COEF_F: begin
            state_in = ST_COEF_D;
         end
         ST_COEF_D: begin
            f_in     = prod_rnd[COEF_WIDTH-1:0];
            state_in = ST_MUL_FB;
         end
         ST_MUL_FB: begin
            d_in     = COEF_ONE - prod_rnd[COEF_WIDTH-1:0];
            state_in = ST_MUL_DB;
         end
         ST_MUL_DB: begin
            // advance the lowpass integrator with the old bandpass
            low_in   = sat_state(EXT_WIDTH'(low_ff) + EXT_WIDTH'(prod_rnd));
            state_in = ST_HIGH;
         end
         ST_HIGH: begin
            high_in  = sat_state(EXT_WIDTH'(x_ff) - EXT_WIDTH'(low_ff)
                                 - EXT_WIDTH'(prod_rnd));
            state_in = ST_MUL_FH;
         end
         ST_MUL_FH: begin
            state_in = ST_BAND;
         end
         ST_BAND: begin
            band_in  = sat_state(EXT_WIDTH'(band_ff) + EXT_WIDTH'(prod_rnd));
            notch_in = sat_state(EXT_WIDTH'(high_ff) + EXT_WIDTH'(low_ff));
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = {to_sample(notch_ff), to_sample(band_ff),
                               to_sample(high_ff), to_sample(low_ff)};
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cutoff_ff    <= CUTOFF_RESET;
         resonance_ff <= RESONANCE_RESET;
         low_ff       <= '0;
         band_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cutoff_ff    <= cutoff_in;
         resonance_ff <= resonance_in;
         low_ff       <= low_in;
         band_ff      <= band_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      high_ff     <= high_in;
      notch_ff    <= notch_in;
      x_ff        <= x_in;
      f_ff        <= f_in;
      d_ff        <= d_in;
      prod_ff     <= prod_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
